// ===== hw/rtl/kmcc_pkg.sv =====
package kmcc_pkg;
	localparam int MaxClusters = 8;
	localparam int IdxW = 3;
	localparam int SumW = 28;
	localparam int CntW = 21;
	localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
	localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
	localparam logic [31:0] LfsrTaps = 32'h8020_0003;

	localparam logic [1:0] KIND_PIXEL = 2'd0;
	localparam logic [1:0] KIND_EOP = 2'd1;
	localparam logic [1:0] KIND_LOAD = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	localparam logic RES_PIXEL = 1'b0;
	localparam logic RES_EOP = 1'b1;

	localparam logic REG_COUNT = 1'b0;
	localparam logic REG_SEED = 1'b1;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [2:0] load_index;
		logic [15:0] load_red;
		logic [15:0] load_green;
		logic [15:0] load_blue;
	} item_t;

	typedef struct packed {
		logic result_kind;
		logic [2:0] cluster_index;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic converged;
	} res_t;

	function automatic logic [31:0] lfsr_step(input logic [31:0] v);
		logic [31:0] n;
		n = v >> 1;
		if (v[0]) n = n ^ LfsrTaps;
		return n;
	endfunction
endpackage

// ===== hw/rtl/kmcc_front.sv =====
module kmcc_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  kmcc_pkg::item_t in_item,
	output logic q_valid,
	input  logic q_ready,
	output kmcc_pkg::item_t q_item
);
	import kmcc_pkg::*;
	// two-entry queue; drop unknown kinds at the door
	item_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;
	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready && (in_item.kind != KIND_NONE);
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_item = mem_q[rp_q];
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== hw/rtl/kmcc_divider.sv =====
module kmcc_divider (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [kmcc_pkg::SumW+7:0] dividend,
	input  logic [kmcc_pkg::CntW-1:0] divisor,
	output logic done,
	output logic [15:0] quotient
);
	import kmcc_pkg::*;
	localparam int NW = SumW + 8;
	// restoring division, one quotient bit a cycle
	logic [NW-1:0] num_q, quo_q;
	logic [CntW:0] rem_q;
	logic [CntW-1:0] den_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [CntW:0] trial;
	assign trial = {rem_q[CntW-1:0], num_q[NW-1]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end
	assign quotient = (quo_q[NW-1:16] != '0) ? 16'hFFFF : quo_q[15:0];
endmodule

// ===== hw/rtl/kmcc_back.sv =====
module kmcc_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_ready,
	input  kmcc_pkg::item_t q_item,
	input  logic [3:0] cluster_count,
	input  logic seed_we,
	input  logic [31:0] seed,
	output logic res_valid,
	input  logic res_ready,
	output kmcc_pkg::res_t res
);
	import kmcc_pkg::*;
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIST = 3'd1;
	localparam logic [2:0] ST_EOP = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	logic [2:0] st_q;
	logic [47:0] cent_q [MaxClusters];
	logic [SumW-1:0] rs_q [MaxClusters], gs_q [MaxClusters], bs_q [MaxClusters];
	logic [CntW-1:0] cnt_q [MaxClusters];
	logic [31:0] lfsr_q;
	item_t it_q;
	logic [IdxW-1:0] i_q, best_q;
	logic [IdxW:0] k;
	logic [33:0] best_d_q;
	logic [1:0] ch_q;
	logic [15:0] nr_q, ng_q;
	logic same_q;
	res_t res_q, res_n;
	logic res_v_q;

	assign k = (cluster_count == 4'd0) ? 4'd1 :
		(cluster_count > 4'(MaxClusters)) ? 4'(MaxClusters) : cluster_count;

	// distance of pixel to centroid i, one centroid per cycle
	logic [15:0] er, eg, eb;
	logic [31:0] sq_r, sq_g, sq_b;
	logic [33:0] d;
	logic [15:0] pr, pg, pb;
	logic [47:0] ci;
	assign ci = cent_q[i_q];
	assign pr = {it_q.red, 8'd0};
	assign pg = {it_q.green, 8'd0};
	assign pb = {it_q.blue, 8'd0};
	assign er = (pr > ci[47:32]) ? pr - ci[47:32] : ci[47:32] - pr;
	assign eg = (pg > ci[31:16]) ? pg - ci[31:16] : ci[31:16] - pg;
	assign eb = (pb > ci[15:0]) ? pb - ci[15:0] : ci[15:0] - pb;
	assign sq_r = er * er;
	assign sq_g = eg * eg;
	assign sq_b = eb * eb;
	assign d = {2'b00, sq_r} + {2'b00, sq_g} + {2'b00, sq_b};

	logic div_start, div_done;
	logic [SumW+7:0] div_num;
	logic [15:0] div_quo;
	logic [SumW-1:0] sel_sum;
	always_comb begin
		case (ch_q)
			2'd0: sel_sum = rs_q[i_q];
			2'd1: sel_sum = gs_q[i_q];
			default: sel_sum = bs_q[i_q];
		endcase
	end
	assign div_num = {sel_sum, 8'd0};
	assign div_start = (st_q == ST_EOP) && (cnt_q[i_q] != '0);
	kmcc_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_num), .divisor(cnt_q[i_q]), .done(div_done), .quotient(div_quo)
	);

	logic out_free;
	assign out_free = !res_v_q || res_ready;
	assign q_ready = (st_q == ST_IDLE);
	assign res_valid = res_v_q;
	assign res = res_q;

	always_comb begin
		res_n = '0;
		if (it_q.kind == KIND_PIXEL) begin
			res_n.result_kind = RES_PIXEL;
			res_n.cluster_index = best_q;
			res_n.out_red = cent_q[best_q][47:40];
			res_n.out_green = cent_q[best_q][31:24];
			res_n.out_blue = cent_q[best_q][15:8];
		end else begin
			res_n.result_kind = RES_EOP;
			res_n.converged = same_q;
		end
	end

	logic [31:0] l1, l2, l3;
	assign l1 = lfsr_step(lfsr_q);
	assign l2 = lfsr_step(l1);
	assign l3 = lfsr_step(l2);
	logic last_i;
	assign last_i = ({1'b0, i_q} == k - 4'd1);

	task automatic commit_c(input logic [47:0] nc);
		if (nc != cent_q[i_q]) same_q <= 1'b0;
		cent_q[i_q] <= nc;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			res_v_q <= 1'b0;
			lfsr_q <= 32'd1;
			for (int j = 0; j < MaxClusters; j++) begin
				cent_q[j] <= '0; rs_q[j] <= '0; gs_q[j] <= '0; bs_q[j] <= '0;
				cnt_q[j] <= '0;
			end
			i_q <= '0; best_q <= '0; ch_q <= '0; same_q <= 1'b1;
		end else begin
			if (seed_we) lfsr_q <= (seed == 32'd0) ? 32'd1 : seed;
			if (st_q == ST_OUT && out_free) res_v_q <= 1'b1;
			else if (res_ready) res_v_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						it_q <= q_item;
						i_q <= '0;
						ch_q <= '0;
						same_q <= 1'b1;
						if (q_item.kind == KIND_PIXEL) st_q <= ST_DIST;
						else if (q_item.kind == KIND_EOP) st_q <= ST_EOP;
						else if ((IdxW+1)'(q_item.load_index) < (IdxW+1)'(MaxClusters))
							cent_q[q_item.load_index] <= {q_item.load_red,
								q_item.load_green, q_item.load_blue};
					end
				end
				ST_DIST: begin
					if (i_q == '0 || d < best_d_q) begin
						best_d_q <= d; best_q <= i_q;
					end
					if (last_i) st_q <= ST_OUT;
					else i_q <= i_q + 1'b1;
				end
				ST_OUT: begin
					if (out_free) begin
						res_q <= res_n;
						if (it_q.kind == KIND_PIXEL) begin
							rs_q[best_q] <= (rs_q[best_q] > SumMax - SumW'(it_q.red)) ?
								SumMax : rs_q[best_q] + SumW'(it_q.red);
							gs_q[best_q] <= (gs_q[best_q] > SumMax - SumW'(it_q.green)) ?
								SumMax : gs_q[best_q] + SumW'(it_q.green);
							bs_q[best_q] <= (bs_q[best_q] > SumMax - SumW'(it_q.blue)) ?
								SumMax : bs_q[best_q] + SumW'(it_q.blue);
							if (cnt_q[best_q] != CntMax) cnt_q[best_q] <= cnt_q[best_q] + 1'b1;
						end else begin
							for (int j = 0; j < MaxClusters; j++) begin
								rs_q[j] <= '0; gs_q[j] <= '0; bs_q[j] <= '0; cnt_q[j] <= '0;
							end
						end
						st_q <= ST_IDLE;
					end
				end
				ST_EOP: begin
					if (cnt_q[i_q] != '0) begin
						st_q <= ST_DIV;
					end else begin
						lfsr_q <= l3;
						commit_c({l1[15:0], l2[15:0], l3[15:0]});
						if (last_i) st_q <= ST_OUT;
						else i_q <= i_q + 1'b1;
					end
				end
				ST_DIV: begin
					// back to ST_EOP to start the next channel's division, or the next cluster's; ST_OUT after the last cluster
					if (div_done) begin
						if (ch_q == 2'd0) begin
							nr_q <= div_quo; ch_q <= 2'd1;
							st_q <= ST_EOP;
						end else if (ch_q == 2'd1) begin
							ng_q <= div_quo; ch_q <= 2'd2;
							st_q <= ST_EOP;
						end else begin
							commit_c({nr_q, ng_q, div_quo});
							ch_q <= 2'd0;
							if (last_i) st_q <= ST_OUT;
							else begin
								i_q <= i_q + 1'b1;
								st_q <= ST_EOP;
							end
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== hw/rtl/kmeans_color_clustering.sv =====
// channel   dir  fields (low bit up)
// s_axis    in   tuser: kind; tdata: red, green, blue, load_index,
//                load_red, load_green, load_blue
// m_axis    out  tuser: result_kind; tdata: cluster_index, out_red, out_green,
//                out_blue, converged
// cfg       in   index 0 cluster_count, 1 random_seed
// A pixel takes one distance per centroid, then the write-back.
// An end of pass runs the bit-serial divider once per channel of each non-empty
// cluster and reseeds each empty cluster from the LFSR.
// Reset clears centroids, sums and counts at once; the LFSR resets to 1.
// A two-entry queue lets input beats land while a result waits on m_axis.
module kmeans_color_clustering (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// kind[1:0]
	input  logic [1:0] s_axis_tuser,
	// red[7:0], green[15:8], blue[23:16], load_index[26:24],
	// load_red[42:27], load_green[58:43], load_blue[74:59]
	input  logic [79:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// result_kind[0]
	output logic m_axis_tuser,
	// cluster_index[2:0], out_red[10:3], out_green[18:11],
	// out_blue[26:19], converged[27]
	output logic [31:0] m_axis_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [31:0] cfg_data
);
	import kmcc_pkg::*;
	item_t in_item, q_item;
	res_t r;
	logic q_valid, q_ready;
	logic [3:0] count_q;

	assign in_item.kind = s_axis_tuser;
	assign in_item.red = s_axis_tdata[7:0];
	assign in_item.green = s_axis_tdata[15:8];
	assign in_item.blue = s_axis_tdata[23:16];
	assign in_item.load_index = s_axis_tdata[26:24];
	assign in_item.load_red = s_axis_tdata[42:27];
	assign in_item.load_green = s_axis_tdata[58:43];
	assign in_item.load_blue = s_axis_tdata[74:59];

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= 4'd4;
		else if (cfg_valid && cfg_index == REG_COUNT) count_q <= cfg_data[3:0];
	end

	kmcc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);
	kmcc_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_item(q_item), .cluster_count(count_q),
		.seed_we(cfg_valid && cfg_index == REG_SEED), .seed(cfg_data),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(r)
	);
	assign m_axis_tuser = r.result_kind;
	assign m_axis_tdata = {4'd0, r.converged, r.out_blue, r.out_green, r.out_red,
		r.cluster_index};

`ifndef NO_ASSERTIONS
	a_pix_no_conv: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == RES_PIXEL |-> !m_axis_tdata[27])
		else $error("conv on pixel");
	a_eop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == RES_EOP |-> m_axis_tdata[26:0] == '0)
		else $error("eop data");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("result dropped");
`endif
endmodule

// ===== dv/tb_kmeans_color_clustering.sv =====
module tb_kmeans_color_clustering;
	timeunit 1ns;
	timeprecision 1ps;
	import kmcc_pkg::*;

	localparam int DrainWait = 1200;
	localparam longint CycleLimit = 3000000;
	localparam int ItemW = $bits(item_t);

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [1:0] s_axis_tuser;
	logic [79:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic m_axis_tuser;
	logic [31:0] m_axis_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [31:0] cfg_data;

	kmeans_color_clustering dut (.*);

	// centroid state mirrored in 8.8 fixed point
	logic [15:0] cen_r [MaxClusters];
	logic [15:0] cen_g [MaxClusters];
	logic [15:0] cen_b [MaxClusters];
	logic [SumW-1:0] sum_r [MaxClusters];
	logic [SumW-1:0] sum_g [MaxClusters];
	logic [SumW-1:0] sum_b [MaxClusters];
	logic [CntW-1:0] members [MaxClusters];
	logic [3:0] k_reg;
	logic [31:0] lfsr;

	res_t pending_results[$];
	int errors;
	longint cycles;
	bit quiet_mode;
	bit hold_req;

	typedef struct {
		item_t it;
		bit typed;
		res_t want;
	} row_t;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [SumW-1:0] sat_sum(logic [SumW-1:0] a, logic [7:0] b);
		logic [SumW:0] s;
		s = a + b;
		return s[SumW] ? SumMax : s[SumW-1:0];
	endfunction

	function automatic logic [15:0] mean16(logic [SumW-1:0] s, logic [CntW-1:0] c);
		longint unsigned m;
		m = (longint'(s) << 8) / c;
		return (m > 64'hFFFF) ? 16'hFFFF : m[15:0];
	endfunction

	function automatic logic [15:0] lfsr_adv();
		logic lsb;
		lsb = lfsr[0];
		lfsr = lfsr >> 1;
		if (lsb) lfsr = lfsr ^ 32'h8020_0003;
		return lfsr[15:0];
	endfunction

	function automatic int active_k();
		if (k_reg == 0) return 1;
		if (k_reg > MaxClusters) return MaxClusters;
		return k_reg;
	endfunction

	function automatic row_t mk_row(item_t it, bit typed, res_t want);
		row_t x;
		x.it = it;
		x.typed = typed;
		x.want = want;
		return x;
	endfunction

	task automatic cluster_step(input item_t it, output bit has, output res_t r);
		int k;
		int best;
		longint unsigned d, best_d, e;
		bit same;
		logic [15:0] nr, ng, nb;
		k = active_k();
		has = 0;
		r = '0;
		case (it.kind)
			KIND_PIXEL: begin
				best = 0;
				best_d = 0;
				for (int i = 0; i < k; i++) begin
					d = 0;
					e = ({it.red, 8'h00} > cen_r[i]) ? {it.red, 8'h00} - cen_r[i]
						: cen_r[i] - {it.red, 8'h00};
					d += e * e;
					e = ({it.green, 8'h00} > cen_g[i]) ? {it.green, 8'h00} - cen_g[i]
						: cen_g[i] - {it.green, 8'h00};
					d += e * e;
					e = ({it.blue, 8'h00} > cen_b[i]) ? {it.blue, 8'h00} - cen_b[i]
						: cen_b[i] - {it.blue, 8'h00};
					d += e * e;
					if (i == 0 || d < best_d) begin
						best_d = d;
						best = i;
					end
				end
				sum_r[best] = sat_sum(sum_r[best], it.red);
				sum_g[best] = sat_sum(sum_g[best], it.green);
				sum_b[best] = sat_sum(sum_b[best], it.blue);
				if (members[best] != CntMax) members[best] = members[best] + 1;
				has = 1;
				r.result_kind = RES_PIXEL;
				r.cluster_index = best[2:0];
				r.out_red = cen_r[best][15:8];
				r.out_green = cen_g[best][15:8];
				r.out_blue = cen_b[best][15:8];
			end
			KIND_EOP: begin
				same = 1;
				for (int i = 0; i < k; i++) begin
					if (members[i] != 0) begin
						nr = mean16(sum_r[i], members[i]);
						ng = mean16(sum_g[i], members[i]);
						nb = mean16(sum_b[i], members[i]);
					end else begin
						nr = lfsr_adv();
						ng = lfsr_adv();
						nb = lfsr_adv();
					end
					if (nr != cen_r[i] || ng != cen_g[i] || nb != cen_b[i]) same = 0;
					cen_r[i] = nr;
					cen_g[i] = ng;
					cen_b[i] = nb;
				end
				for (int i = 0; i < MaxClusters; i++) begin
					sum_r[i] = '0;
					sum_g[i] = '0;
					sum_b[i] = '0;
					members[i] = '0;
				end
				has = 1;
				r.result_kind = RES_EOP;
				r.converged = same;
			end
			KIND_LOAD: begin
				if (it.load_index < MaxClusters) begin
					cen_r[it.load_index] = it.load_red;
					cen_g[it.load_index] = it.load_green;
					cen_b[it.load_index] = it.load_blue;
				end
			end
			default: ;
		endcase
	endtask

	function automatic int gap_len();
		if (quiet_mode) return 0;
		if ($urandom_range(0, 99) < 60) return 0;
		if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// typed_want is queued instead of the predicted beat when typed is set
	task automatic send(input item_t it, input bit typed = 0, input res_t typed_want = '0);
		bit has;
		res_t r;
		int g;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.kind;
		s_axis_tdata <= {5'b00000, it.load_blue, it.load_green, it.load_red, it.load_index,
			it.blue, it.green, it.red};
		do @(posedge clk); while (!s_axis_tready);
		cluster_step(it, has, r);
		if (has) pending_results.insert(pending_results.size(), typed ? typed_want : r);
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic stop_sending();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_results.size() > 0) @(posedge clk);
		repeat (DrainWait) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_COUNT) k_reg = val[3:0];
		else begin
			lfsr = (val == 0) ? 32'd1 : val;
		end
		@(posedge clk);
	endtask

	function automatic item_t pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		item_t it;
		it = '0;
		it.kind = KIND_PIXEL;
		it.red = r;
		it.green = g;
		it.blue = b;
		return it;
	endfunction

	function automatic item_t load(logic [2:0] idx, logic [15:0] r, logic [15:0] g,
			logic [15:0] b);
		item_t it;
		it = '0;
		it.kind = KIND_LOAD;
		it.load_index = idx;
		it.load_red = r;
		it.load_green = g;
		it.load_blue = b;
		return it;
	endfunction

	function automatic item_t noise_item();
		item_t it;
		it = ItemW'({$urandom, $urandom, $urandom});
		return it;
	endfunction

	function automatic res_t pix_res(logic [2:0] idx, logic [7:0] r, logic [7:0] g,
			logic [7:0] b);
		res_t x;
		x = '0;
		x.result_kind = RES_PIXEL;
		x.cluster_index = idx;
		x.out_red = r;
		x.out_green = g;
		x.out_blue = b;
		return x;
	endfunction

	// result checker
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.result_kind = m_axis_tuser;
			got.cluster_index = m_axis_tdata[2:0];
			got.out_red = m_axis_tdata[10:3];
			got.out_green = m_axis_tdata[18:11];
			got.out_blue = m_axis_tdata[26:19];
			got.converged = m_axis_tdata[27];
			if (pending_results.size() == 0) begin
				$error("unexpected result beat %h", m_axis_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.result_kind !== want.result_kind) begin
					$error("result_kind exp %0d got %0d", want.result_kind, got.result_kind);
					errors++;
				end
				if (got.cluster_index !== want.cluster_index) begin
					$error("cluster_index exp %0d got %0d", want.cluster_index,
						got.cluster_index);
					errors++;
				end
				if (got.out_red !== want.out_red) begin
					$error("out_red exp %h got %h", want.out_red, got.out_red);
					errors++;
				end
				if (got.out_green !== want.out_green) begin
					$error("out_green exp %h got %h", want.out_green, got.out_green);
					errors++;
				end
				if (got.out_blue !== want.out_blue) begin
					$error("out_blue exp %h got %h", want.out_blue, got.out_blue);
					errors++;
				end
				if (got.converged !== want.converged) begin
					$error("converged exp %0d got %0d", want.converged, got.converged);
					errors++;
				end
			end
		end
	end

	// output backpressure
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end else if (quiet_mode) begin
				m_axis_tready <= 1'b1;
			end else if ($urandom_range(0, 99) < 2) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(10, 50)) @(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) < 70);
			end
		end
	end

	initial begin
		row_t rows[$];
		row_t rw;
		item_t px_set[$];
		int n, passes;
		logic [3:0] k_pick;
		logic [31:0] seed_pick;

		errors = 0;
		cycles = 0;
		quiet_mode = 0;
		hold_req = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = '0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_COUNT;
		cfg_data = '0;
		k_reg = 4'd4;
		lfsr = 32'd1;
		for (int i = 0; i < MaxClusters; i++) begin
			cen_r[i] = '0; cen_g[i] = '0; cen_b[i] = '0;
			sum_r[i] = '0; sum_g[i] = '0; sum_b[i] = '0;
			members[i] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; typed rows expect what the reset state and the loads before them give
		rows.insert(rows.size(), mk_row(pixel(8'h00, 8'h00, 8'h00), 1, pix_res(0, 0, 0, 0)));
		rows.insert(rows.size(), mk_row(pixel(8'hFF, 8'hFF, 8'hFF), 1, pix_res(0, 0, 0, 0)));
		rw.it = '1; rw.it.kind = KIND_NONE; rw.typed = 0; rw.want = '0;
		rows.insert(rows.size(), rw);
		rows.insert(rows.size(), mk_row(load(3'd7, 16'hFFFF, 16'h0000, 16'hFFFF), 0, '0));
		rows.insert(rows.size(), mk_row(load(3'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0, '0));
		rows.insert(rows.size(), mk_row(pixel(8'hFF, 8'hFF, 8'hFF), 1,
			pix_res(1, 8'hFF, 8'hFF, 8'hFF)));
		rows.insert(rows.size(), mk_row(pixel(8'h80, 8'h00, 8'hFF), 0, '0));
		rows.insert(rows.size(), mk_row(load(3'd2, 16'h8000, 16'h0000, 16'hFF00), 0, '0));
		rows.insert(rows.size(), mk_row(pixel(8'h80, 8'h00, 8'hFF), 1,
			pix_res(2, 8'h80, 8'h00, 8'hFF)));
		// equal centroids: lower index wins
		rows.insert(rows.size(), mk_row(load(3'd3, 16'h8000, 16'h0000, 16'hFF00), 0, '0));
		rows.insert(rows.size(), mk_row(pixel(8'h80, 8'h00, 8'hFF), 1,
			pix_res(2, 8'h80, 8'h00, 8'hFF)));
		rows.insert(rows.size(), mk_row(pixel(8'h7F, 8'h01, 8'hFE), 0, '0));
		rw.it = '0; rw.it.kind = KIND_EOP; rw.typed = 0;
		rows.insert(rows.size(), rw);
		// every cluster empty: all reseeded
		rows.insert(rows.size(), rw);
		rows.insert(rows.size(), mk_row(pixel(8'h12, 8'h34, 8'h56), 0, '0));
		rows.insert(rows.size(), rw);
		foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].want);
		stop_sending();
		drain();

		for (int ph = 0; ph < 24; ph++) begin
			case (ph % 6)
				0: k_pick = 4'd1;
				1: k_pick = 4'd8;
				2: k_pick = 4'd0;
				3: k_pick = 4'd15;
				default: k_pick = 4'($urandom_range(1, 8));
			endcase
			write_reg(REG_COUNT, {28'd0, k_pick});
			case (ph % 5)
				0: seed_pick = 32'd0;
				1: seed_pick = 32'hFFFF_FFFF;
				2: seed_pick = 32'd1;
				default: seed_pick = $urandom;
			endcase
			if (ph % 3 != 2) write_reg(REG_SEED, seed_pick);
			quiet_mode = (ph % 4 == 3);
			if (ph % 2 == 0)
				for (int i = 0; i < MaxClusters; i++)
					send(load(3'(i), 16'($urandom), 16'($urandom), 16'($urandom)));
			px_set.delete();
			n = $urandom_range(10, 20);
			for (int i = 0; i < n; i++) begin
				if (ph % 3 == 0)
					px_set.insert(px_set.size(),
						pixel(8'($urandom), 8'($urandom), 8'($urandom)));
				else
					px_set.insert(px_set.size(),
						pixel(8'($urandom_range(0, 3) * 80 + $urandom_range(0, 15)),
						8'($urandom_range(0, 3) * 80 + $urandom_range(0, 15)),
						8'($urandom_range(0, 3) * 80 + $urandom_range(0, 15))));
			end
			if (ph == 7) hold_req = 1;
			// repeated passes over the same frame let the centroids settle
			passes = $urandom_range(3, 5);
			for (int p = 0; p < passes; p++) begin
				foreach (px_set[i]) begin
					if ($urandom_range(0, 99) < 4) send(noise_item());
					send(px_set[i]);
				end
				rw.it = '0; rw.it.kind = KIND_EOP;
				send(rw.it);
			end
			if (ph == 13) begin
				stop_sending();
				while (pending_results.size() > 0) @(posedge clk);
				for (int i = 0; i < 40; i++) send(noise_item());
			end
			stop_sending();
			drain();
		end

		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
